@@ src/tpbe_pkg.sv @@
// Shared types and constants for the transport-stream PCR bit-rate estimator.
package tpbe_pkg;

    localparam int unsigned IDX_W  = 32;
    localparam int unsigned BASE_W = 33;
    localparam int unsigned EXT_W  = 9;
    localparam int unsigned RATE_W = 32;
    localparam int unsigned STAT_W = 2;

    // 188 bytes * 8 bits * 27 MHz as one constant factor of the numerator.
    localparam int unsigned K_W    = 36;
    localparam logic [K_W-1:0] RATE_K = K_W'(64'd40608000000);

    // Numerator is packet distance times the factor above.
    localparam int unsigned NUM_W  = IDX_W + K_W;
    // A positive PCR distance stays below 2^42; the signed form needs one more bit.
    localparam int unsigned DEN_W  = 42;
    localparam int unsigned DPCR_W = DEN_W + 1;

    localparam int unsigned MUL_STEPS = IDX_W;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned SAT_STEPS = NUM_W - RATE_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_FIRST = 2'd1;
    localparam logic [1:0] SEEN_DONE  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]  packet_index;
        logic              has_pcr;
        logic [BASE_W-1:0] clock_base;
        logic [EXT_W-1:0]  pcr_ext;
        logic              new_scan;
        logic              last_packet;
    } t_in_word;

    typedef struct packed {
        logic [RATE_W-1:0] bit_rate;
        logic [STAT_W-1:0] status;
    } t_out_word;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] prod;
    } t_mul_res;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [RATE_W-1:0] quo;
    } t_div_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ src/tpbe_mul.sv @@
// Bit-serial shift-add multiplier: packet distance times the constant rate factor.
module tpbe_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpbe_pkg::IDX_W-1:0] i_dpkt,
    output tpbe_pkg::t_mul_res         o_res
);

    logic                           r_busy;
    logic                           r_done;
    logic [tpbe_pkg::MUL_CNT_W-1:0] r_cnt;
    logic [tpbe_pkg::NUM_W-1:0]     r_acc;
    logic [tpbe_pkg::K_W:0]         w_sum;
    logic [tpbe_pkg::NUM_W-1:0]     n_acc;

    // The upper part holds the partial product, the lower part the multiplier bits
    // that are still to be used; one bit is consumed per cycle.
    always_comb begin
        w_sum = {1'b0, r_acc[tpbe_pkg::NUM_W-1:tpbe_pkg::IDX_W]}
              + (r_acc[0] ? {1'b0, tpbe_pkg::RATE_K} : '0);
        n_acc = {w_sum, r_acc[tpbe_pkg::IDX_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tpbe_pkg::MUL_CNT_W'(tpbe_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{tpbe_pkg::K_W{1'b0}}, i_dpkt};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_res.done = r_done;
    assign o_res.prod = r_acc;

endmodule

@@ src/tpbe_div.sv @@
// Restoring divider that retires one quotient bit per cycle and flags overflow.
module tpbe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpbe_pkg::NUM_W-1:0] i_num,
    input  logic [tpbe_pkg::DEN_W-1:0] i_den,
    output tpbe_pkg::t_div_res         o_res
);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_sat;
    logic [tpbe_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tpbe_pkg::NUM_W-1:0]     r_num;
    logic [tpbe_pkg::DEN_W-1:0]     r_den;
    logic [tpbe_pkg::DEN_W-1:0]     r_rem;
    logic [tpbe_pkg::RATE_W-1:0]    r_quo;
    logic [tpbe_pkg::DEN_W:0]       w_trial;
    logic [tpbe_pkg::DEN_W:0]       w_diff;
    logic                           w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[tpbe_pkg::NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sat  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                // Any set quotient bit above the 32 kept bits means overflow.
                if (w_ge && (r_cnt < tpbe_pkg::DIV_CNT_W'(tpbe_pkg::SAT_STEPS))) begin
                    r_sat <= 1'b1;
                end
                if (r_cnt == tpbe_pkg::DIV_CNT_W'(tpbe_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[tpbe_pkg::NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[tpbe_pkg::DEN_W-1:0] : w_trial[tpbe_pkg::DEN_W-1:0];
            r_quo <= {r_quo[tpbe_pkg::RATE_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_quo;

endmodule

@@ src/ts_pcr_bitrate_estimator_top.sv @@
// Top level of the transport-stream PCR bit-rate estimator.
//
//   Channel   Direction   Valid        Stall        Word
//   -------   ---------   ----------   ----------   -------------------------
//   input     in          i_in_valid   o_in_stall   i_in_word  (t_in_word)
//   result    out         o_out_valid  i_out_stall  o_out_word (t_out_word)
//
// A packet word that gives no result is taken while the block is idle. A word
// that ends the scan without a second PCR goes from taking the word to handing
// over its result. A second PCR word goes through taking the word, forming the PCR
// distance, checking its sign, the bit-serial multiplier (a shift-add step per bit
// of the packet distance, then its done flag), the divider (a step per numerator bit,
// then its done flag) and the hand-over; a bad PCR interval leaves after the check.
// The synchronous active-low reset clears the scan state and empties the output.
// A finished result waits in its own register while the output is stalled, so the
// block goes back to taking input as soon as the result has moved on; a new result
// is held back only while the previous one still sits stalled in that register.
module ts_pcr_bitrate_estimator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tpbe_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tpbe_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    tpbe_pkg::t_state r_state;
    tpbe_pkg::t_state n_state;
    logic [1:0]       r_seen;
    logic [1:0]       n_seen;
    logic [1:0]       w_seen_eff;

    // Stored first PCR of the scan.
    logic [tpbe_pkg::IDX_W-1:0]  r_first_idx;
    logic [tpbe_pkg::IDX_W-1:0]  n_first_idx;
    logic [tpbe_pkg::BASE_W-1:0] r_first_base;
    logic [tpbe_pkg::BASE_W-1:0] n_first_base;
    logic [tpbe_pkg::EXT_W-1:0]  r_first_ext;
    logic [tpbe_pkg::EXT_W-1:0]  n_first_ext;

    // Differences and second extension taken when the second PCR arrives, and the PCR distance.
    logic [tpbe_pkg::IDX_W-1:0]  r_dpkt;
    logic [tpbe_pkg::IDX_W-1:0]  n_dpkt;
    logic [tpbe_pkg::BASE_W-1:0] r_dbase;
    logic [tpbe_pkg::BASE_W-1:0] n_dbase;
    logic [tpbe_pkg::EXT_W-1:0]  r_ext;
    logic [tpbe_pkg::EXT_W-1:0]  n_ext;
    logic [tpbe_pkg::DPCR_W-1:0] r_dpcr;
    logic [tpbe_pkg::DPCR_W-1:0] n_dpcr;
    logic [tpbe_pkg::DPCR_W-1:0] w_base_wide;

    tpbe_pkg::t_out_word r_res;
    tpbe_pkg::t_out_word n_res;
    logic                r_out_valid;
    logic                n_out_valid;
    tpbe_pkg::t_out_word r_out_word;
    tpbe_pkg::t_out_word n_out_word;

    logic               w_mul_start;
    logic               w_div_start;
    tpbe_pkg::t_mul_res w_mul;
    tpbe_pkg::t_div_res w_div;

    tpbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_dpkt  (r_dpkt),
        .o_res   (w_mul)
    );

    tpbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mul.prod),
        .i_den   (r_dpcr[tpbe_pkg::DEN_W-1:0]),
        .o_res   (w_div)
    );

    // A new scan clears the PCR count before the word itself is looked at.
    assign w_seen_eff  = i_in_word.new_scan ? tpbe_pkg::SEEN_NONE : r_seen;
    assign w_base_wide = tpbe_pkg::DPCR_W'(r_dbase);

    always_comb begin
        n_state      = r_state;
        n_seen       = r_seen;
        n_first_idx  = r_first_idx;
        n_first_base = r_first_base;
        n_first_ext  = r_first_ext;
        n_dpkt       = r_dpkt;
        n_dbase      = r_dbase;
        n_ext        = r_ext;
        n_dpcr       = r_dpcr;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;
        w_mul_start  = 1'b0;
        w_div_start  = 1'b0;

        unique case (r_state)
            tpbe_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_seen = w_seen_eff;
                    if (w_seen_eff != tpbe_pkg::SEEN_DONE) begin
                        if (i_in_word.has_pcr && (w_seen_eff == tpbe_pkg::SEEN_FIRST)) begin
                            // Second PCR: both differences wrap at their field widths.
                            n_seen  = tpbe_pkg::SEEN_DONE;
                            n_dpkt  = i_in_word.packet_index - r_first_idx;
                            n_dbase = i_in_word.clock_base - r_first_base;
                            n_ext   = i_in_word.pcr_ext;
                            n_state = tpbe_pkg::S_PREP;
                        end else begin
                            if (i_in_word.has_pcr) begin
                                n_first_idx  = i_in_word.packet_index;
                                n_first_base = i_in_word.clock_base;
                                n_first_ext  = i_in_word.pcr_ext;
                                n_seen       = tpbe_pkg::SEEN_FIRST;
                            end
                            if (i_in_word.last_packet) begin
                                n_seen         = tpbe_pkg::SEEN_DONE;
                                n_res.bit_rate = '0;
                                n_res.status   = tpbe_pkg::ST_NONE;
                                n_state        = tpbe_pkg::S_DONE;
                            end
                        end
                    end
                end
            end
            tpbe_pkg::S_PREP: begin
                // Base difference times 300 as 256 + 32 + 8 + 4, plus the
                // extension difference taken second minus first.
                n_dpcr = (w_base_wide << 8) + (w_base_wide << 5)
                       + (w_base_wide << 3) + (w_base_wide << 2)
                       + tpbe_pkg::DPCR_W'(r_ext)
                       - tpbe_pkg::DPCR_W'(r_first_ext);
                n_state = tpbe_pkg::S_CHK;
            end
            tpbe_pkg::S_CHK: begin
                if (r_dpcr[tpbe_pkg::DPCR_W-1] || (r_dpcr == '0)) begin
                    n_res.bit_rate = '0;
                    n_res.status   = tpbe_pkg::ST_BAD;
                    n_state        = tpbe_pkg::S_DONE;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = tpbe_pkg::S_MUL;
                end
            end
            tpbe_pkg::S_MUL: begin
                if (w_mul.done) begin
                    w_div_start = 1'b1;
                    n_state     = tpbe_pkg::S_DIV;
                end
            end
            tpbe_pkg::S_DIV: begin
                if (w_div.done) begin
                    if (w_div.sat) begin
                        n_res.bit_rate = '1;
                        n_res.status   = tpbe_pkg::ST_SAT;
                    end else begin
                        n_res.bit_rate = w_div.quo;
                        n_res.status   = tpbe_pkg::ST_FOUND;
                    end
                    n_state = tpbe_pkg::S_DONE;
                end
            end
            tpbe_pkg::S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = tpbe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpbe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpbe_pkg::S_IDLE;
            r_seen      <= tpbe_pkg::SEEN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_idx  <= n_first_idx;
        r_first_base <= n_first_base;
        r_first_ext  <= n_first_ext;
        r_dpkt       <= n_dpkt;
        r_dbase      <= n_dbase;
        r_ext        <= n_ext;
        r_dpcr       <= n_dpcr;
        r_res        <= n_res;
        r_out_word   <= n_out_word;
    end

    assign o_in_stall  = (r_state != tpbe_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ src/tpbe_chk.sv @@
// Port-level checker for the bit-rate estimator and its bind to the top level.
module tpbe_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input tpbe_pkg::t_in_word  i_in_word,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input tpbe_pkg::t_out_word i_out_word,
    input logic                i_out_stall
);

    // A stalled packet word stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("packet word changed while stalled");

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed while stalled");

    // Statuses without a rate carry a zero rate.
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_word.status == tpbe_pkg::ST_BAD) ||
                        (i_out_word.status == tpbe_pkg::ST_NONE))
        |-> (i_out_word.bit_rate == '0))
        else $error("nonzero rate with bad or missing PCR status");

    // A saturated rate is all ones.
    a_sat_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.status == tpbe_pkg::ST_SAT)
        |-> (i_out_word.bit_rate == '1))
        else $error("saturated status without all-ones rate");

    // A new result only appears after the block has been busy with its word.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared while the input side was open");

endmodule

bind ts_pcr_bitrate_estimator_top tpbe_chk u_tpbe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
